// ===== rtl/ugc_pkg.sv =====
`timescale 1ns / 1ps

package ugc_pkg;

   localparam logic [1:0] REQ_ADD   = 2'd0;
   localparam logic [1:0] REQ_DRAIN = 2'd1;
   localparam logic [1:0] REQ_FLUSH = 2'd2;
   localparam logic [1:0] REQ_NOP   = 2'd3;

   localparam logic [2:0] STS_OK      = 3'd0;
   localparam logic [2:0] STS_FULL    = 3'd1;
   localparam logic [2:0] STS_READY   = 3'd2;
   localparam logic [2:0] STS_DATA    = 3'd3;
   localparam logic [2:0] STS_BUSY    = 3'd4;
   localparam logic [2:0] STS_FLUSHED = 3'd5;

   localparam logic [3:0] CSR_WINDOW_CALLS = 4'd0;
   localparam logic [3:0] CSR_ROW_LEN      = 4'd1;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [63:0] id;
      logic [3:0]         elem_index;
      logic signed [31:0] grad_value;
      logic               last_of_call;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [63:0] out_id;
      logic [3:0]         out_elem_index;
      logic signed [31:0] out_sum;
      logic               out_last;
      logic [7:0]         pending_calls;
   } rsp_word_type;

endpackage

// ===== rtl/ugc_key_mem.sv =====
`timescale 1ns / 1ps

module ugc_key_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          en,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [63:0]   wdata,
   output logic [63:0]   rdata
);
   logic [63:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end
         rdata <= mem[addr];
      end
   end
endmodule

// ===== rtl/ugc_sum_mem.sv =====
`timescale 1ns / 1ps

module ugc_sum_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int W     = 32
) (
   input  logic          clock,
   input  logic          en,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [W-1:0]  wdata,
   output logic [W-1:0]  rdata
);
   logic [W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end
         rdata <= mem[addr];
      end
   end
endmodule

// ===== rtl/unique_id_gradient_coalescer.sv =====
`timescale 1ns / 1ps
// channel  ports                          word
// req      req_valid req_stall req_word   ugc_pkg::req_word_type
// rsp      rsp_valid rsp_stall rsp_word   ugc_pkg::rsp_word_type
// csr      csr_valid csr_ready csr_index  csr_data, always ready
// one word at a time; flush, idle drain, no-op and add while ready go IDLE then OUT
// drain of data goes DRN then OUT, add past row end FIN then OUT; an add searches in SRCH
// then a known id goes ADDR, ADDW, FIN, OUT; a new id first clears its ROW_MAX sums in CLR
// a full table drop goes FIN then OUT; the key memory is probed one slot a cycle
// a stalled rsp register keeps the word waiting in OUT; reset clears control state only

module unique_id_gradient_coalescer #(
   parameter int TABLE_DEPTH = 64,
   parameter int ROW_MAX     = 16,
   parameter int SUM_WIDTH   = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ugc_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ugc_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [3:0]            csr_index,
   input  logic [7:0]            csr_data
);
   import ugc_pkg::*;

   localparam int SW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int KW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
   localparam int AW = $clog2(TABLE_DEPTH * ROW_MAX);
   localparam int LW = ($clog2(ROW_MAX + 1) > 5) ? $clog2(ROW_MAX + 1) : 5;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SRCH = 3'd1;
   localparam logic [2:0] ST_CLR  = 3'd2;
   localparam logic [2:0] ST_ADDR = 3'd3;
   localparam logic [2:0] ST_ADDW = 3'd4;
   localparam logic [2:0] ST_DRN  = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;

   logic [2:0]           state_ff, state_in;
   logic [7:0]           window_ff, window_in;
   logic [4:0]           row_len_ff, row_len_in;
   logic [CW-1:0]        entry_ff, entry_in;
   logic [7:0]           calls_ff, calls_in;
   logic                 ready_ff, ready_in;
   logic [SW-1:0]        drn_ent_ff, drn_ent_in;
   logic [KW-1:0]        drn_elem_ff, drn_elem_in;
   req_word_type         req_ff, req_in;
   logic [CW-1:0]        probe_ff, probe_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [SW-1:0]        cmp_slot_ff, cmp_slot_in;
   logic [SW-1:0]        slot_ff, slot_in;
   logic [KW-1:0]        clr_ff, clr_in;
   rsp_word_type         res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_word_ff, rsp_word_in;

   logic                 key_en, key_we;
   logic [SW-1:0]        key_addr;
   logic [63:0]          key_rdata;
   logic                 sum_en, sum_we;
   logic [AW-1:0]        sum_addr;
   logic [SUM_WIDTH-1:0] sum_wdata, sum_rdata;

   logic [LW-1:0]        rl;
   logic                 accept, issue, hit, row_end;
   logic [7:0]           calls_inc;
   logic [AW-1:0]        add_addr, drn_addr;

   ugc_key_mem #(.DEPTH(TABLE_DEPTH), .AW(SW)) u_key (
      .clock, .en(key_en), .we(key_we), .addr(key_addr),
      .wdata(req_ff.id), .rdata(key_rdata)
   );

   ugc_sum_mem #(.DEPTH(TABLE_DEPTH * ROW_MAX), .AW(AW), .W(SUM_WIDTH)) u_sum (
      .clock, .en(sum_en), .we(sum_we), .addr(sum_addr),
      .wdata(sum_wdata), .rdata(sum_rdata)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      rl = LW'(row_len_ff);
      if (row_len_ff == 5'd0) begin
         rl = LW'(1);
      end else if (rl > LW'(ROW_MAX)) begin
         rl = LW'(ROW_MAX);
      end
      add_addr  = AW'(slot_ff) * AW'(ROW_MAX) + AW'(KW'(req_ff.elem_index));
      drn_addr  = AW'(drn_ent_ff) * AW'(ROW_MAX) + AW'(drn_elem_ff);
      issue     = (probe_ff < entry_ff);
      hit       = cmp_vld_ff && (key_rdata == req_ff.id);
      row_end   = (LW'(drn_elem_ff) + LW'(1)) >= rl;
      calls_inc = (calls_ff == 8'hFF) ? calls_ff : calls_ff + 8'd1;
   end

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      row_len_in   = row_len_ff;
      entry_in     = entry_ff;
      calls_in     = calls_ff;
      ready_in     = ready_ff;
      drn_ent_in   = drn_ent_ff;
      drn_elem_in  = drn_elem_ff;
      req_in       = req_ff;
      probe_in     = probe_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_slot_in  = cmp_slot_ff;
      slot_in      = slot_ff;
      clr_in       = clr_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      key_en       = 1'b0;
      key_we       = 1'b0;
      key_addr     = drn_ent_ff;
      sum_en       = 1'b0;
      sum_we       = 1'b0;
      sum_addr     = drn_addr;
      sum_wdata    = '0;

      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_WINDOW_CALLS) begin
            window_in = csr_data;
         end else if (csr_index == CSR_ROW_LEN) begin
            row_len_in = csr_data[4:0];
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in     = req_word;
               res_in     = '0;
               res_in.status = STS_BUSY;
               res_in.pending_calls = calls_ff;
               probe_in   = '0;
               cmp_vld_in = 1'b0;
               state_in   = ST_OUT;
               priority if (req_word.req_type == REQ_ADD) begin
                  if (!ready_ff) begin
                     state_in = (LW'(req_word.elem_index) >= rl) ? ST_FIN : ST_SRCH;
                  end
               end else if (req_word.req_type == REQ_DRAIN) begin
                  if (ready_ff && entry_ff == '0) begin
                     res_in.out_last      = 1'b1;
                     res_in.pending_calls = 8'd0;
                     entry_in    = '0;
                     calls_in    = '0;
                     ready_in    = 1'b0;
                     drn_ent_in  = '0;
                     drn_elem_in = '0;
                  end else if (ready_ff) begin
                     key_en   = 1'b1;
                     sum_en   = 1'b1;
                     state_in = ST_DRN;
                  end
               end else if (req_word.req_type == REQ_FLUSH) begin
                  res_in.status = STS_FLUSHED;
                  entry_in    = '0;
                  calls_in    = '0;
                  ready_in    = 1'b0;
                  drn_ent_in  = '0;
                  drn_elem_in = '0;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_SRCH: begin
            if (hit) begin
               slot_in  = cmp_slot_ff;
               state_in = ST_ADDR;
            end else if (!cmp_vld_ff && probe_ff == entry_ff) begin
               if (entry_ff < CW'(TABLE_DEPTH)) begin
                  key_en   = 1'b1;
                  key_we   = 1'b1;
                  key_addr = SW'(entry_ff);
                  slot_in  = SW'(entry_ff);
                  entry_in = entry_ff + CW'(1);
                  clr_in   = '0;
                  state_in = ST_CLR;
               end else begin
                  res_in.status = STS_FULL;
                  state_in = ST_FIN;
               end
            end else begin
               key_en      = issue;
               key_addr    = SW'(probe_ff);
               cmp_vld_in  = issue;
               cmp_slot_in = SW'(probe_ff);
               if (issue) begin
                  probe_in = probe_ff + CW'(1);
               end
            end
         end
         ST_CLR: begin
            sum_en   = 1'b1;
            sum_we   = 1'b1;
            sum_addr = AW'(slot_ff) * AW'(ROW_MAX) + AW'(clr_ff);
            clr_in   = clr_ff + KW'(1);
            if (clr_ff == KW'(ROW_MAX - 1)) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            sum_en   = 1'b1;
            sum_addr = add_addr;
            state_in = ST_ADDW;
         end
         ST_ADDW: begin
            sum_en    = 1'b1;
            sum_we    = 1'b1;
            sum_addr  = add_addr;
            sum_wdata = sum_rdata + SUM_WIDTH'(req_ff.grad_value);
            res_in.status = STS_OK;
            state_in  = ST_FIN;
         end
         ST_FIN: begin
            if (req_ff.last_of_call) begin
               calls_in = calls_inc;
               res_in.pending_calls = calls_inc;
               if (calls_inc >= window_ff) begin
                  ready_in = 1'b1;
                  res_in.status = STS_READY;
               end
            end
            state_in = ST_OUT;
         end
         ST_DRN: begin
            res_in.status         = STS_DATA;
            res_in.out_id         = key_rdata;
            res_in.out_elem_index = 4'(drn_elem_ff);
            res_in.out_sum        = 32'(sum_rdata);
            if (row_end && (CW'(drn_ent_ff) + CW'(1) >= entry_ff)) begin
               res_in.out_last = 1'b1;
               entry_in    = '0;
               calls_in    = '0;
               ready_in    = 1'b0;
               drn_ent_in  = '0;
               drn_elem_in = '0;
            end else if (row_end) begin
               drn_ent_in  = drn_ent_ff + SW'(1);
               drn_elem_in = '0;
            end else begin
               drn_elem_in = drn_elem_ff + KW'(1);
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= 8'd1;
         row_len_ff   <= 5'd1;
         entry_ff     <= '0;
         calls_ff     <= '0;
         ready_ff     <= 1'b0;
         drn_ent_ff   <= '0;
         drn_elem_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         row_len_ff   <= row_len_in;
         entry_ff     <= entry_in;
         calls_ff     <= calls_in;
         ready_ff     <= ready_in;
         drn_ent_ff   <= drn_ent_in;
         drn_elem_ff  <= drn_elem_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff   <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      probe_ff    <= probe_in;
      cmp_slot_ff <= cmp_slot_in;
      slot_ff     <= slot_in;
      clr_ff      <= clr_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   a_entry_bound: assert property (@(posedge clock) disable iff (reset)
      entry_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_drain_idle: assert property (@(posedge clock) disable iff (reset)
      !ready_ff |-> (drn_ent_ff == '0 && drn_elem_ff == '0))
      else $error("drain pointer moved outside ready batch");

   a_drain_range: assert property (@(posedge clock) disable iff (reset)
      (ready_ff && entry_ff != '0) |-> (CW'(drn_ent_ff) < entry_ff))
      else $error("drain pointer past last entry");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import ugc_pkg::*;

   localparam int DEPTH = 64;
   localparam int ROWMAX = 16;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [3:0] csr_index = '0;
   logic [7:0] csr_data = '0;

   unique_id_gradient_coalescer uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // coalescer state mirror
   logic [63:0] keys [DEPTH];
   logic [31:0] sums [DEPTH*ROWMAX];
   int unsigned n_ids, n_calls, d_ent, d_elem;
   bit ready_flag;
   logic [7:0] win_calls;
   logic [4:0] row_length;

   req_word_type pending_words[$];
   rsp_word_type expected_rsps[$];
   int errors = 0;
   int n_rsp = 0, n_full = 0, n_drain = 0, n_ready = 0;
   int idle_cycles = 0;
   bit timed_out = 0;

   function automatic void clear_batch();
      n_ids = 0; n_calls = 0; ready_flag = 0; d_ent = 0; d_elem = 0;
   endfunction

   function automatic void enqueue(req_word_type w);
      pending_words.insert(pending_words.size(), w);
   endfunction

   function automatic rsp_word_type coalesce(req_word_type w);
      rsp_word_type r;
      int unsigned rl, slot, e, k;
      bit found, row_end;
      rl = (row_length < 1) ? 1 : (row_length > ROWMAX ? ROWMAX : row_length);
      r = '0;
      r.status = STS_BUSY;
      r.pending_calls = 8'(n_calls);
      if (w.req_type == REQ_ADD) begin
         if (!ready_flag) begin
            if (w.elem_index < rl) begin
               found = 0;
               for (slot = 0; slot < n_ids; slot++)
                  if (keys[slot] == w.id) begin
                     found = 1;
                     break;
                  end
               if (!found && n_ids < DEPTH) begin
                  slot = n_ids;
                  keys[slot] = w.id;
                  for (int i = 0; i < ROWMAX; i++) sums[slot*ROWMAX+i] = '0;
                  n_ids++;
                  found = 1;
               end
               if (found) begin
                  sums[slot*ROWMAX+w.elem_index] += w.grad_value;
                  r.status = STS_OK;
               end else r.status = STS_FULL;
            end
            if (w.last_of_call) begin
               if (n_calls < 255) n_calls++;
               if (n_calls >= ((win_calls == 0) ? 1 : win_calls)) begin
                  ready_flag = 1;
                  r.status = STS_READY;
               end
            end
         end
         r.pending_calls = 8'(n_calls);
      end else if (w.req_type == REQ_DRAIN) begin
         if (ready_flag) begin
            if (n_ids == 0) begin
               r.out_last = 1;
               clear_batch();
               r.pending_calls = 0;
            end else begin
               e = d_ent; k = d_elem;
               row_end = (k + 1 >= rl);
               if (e >= n_ids) e = n_ids - 1;
               if (k >= ROWMAX) k = ROWMAX - 1;
               r.status = STS_DATA;
               r.out_id = keys[e];
               r.out_elem_index = 4'(k);
               r.out_sum = sums[e*ROWMAX+k];
               if (row_end && e + 1 >= n_ids) begin
                  r.out_last = 1;
                  clear_batch();
               end else if (row_end) begin
                  d_ent = e + 1; d_elem = 0;
               end else begin
                  d_ent = e; d_elem = k + 1;
               end
            end
         end
      end else if (w.req_type == REQ_FLUSH) begin
         r.status = STS_FLUSHED;
         clear_batch();
      end
      return r;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h", what, got, want);
   endtask

   // sampled stall for the driver, captured at the rising edge
   logic req_stall_s = 1'b0;

   // driver: bursts and gaps
   int burst_left = 0, gap_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!(req_valid && req_stall_s)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_word <= pending_words.pop_front();
               req_valid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 30);
               end
               burst_left--;
               if (burst_left == 0 && $urandom_range(0, 2) != 0)
                  gap_left = $urandom_range(1, 12);
            end else req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern
   int stall_mode = 0;
   always @(negedge clock) begin
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) != 0);
      endcase
   end

   always @(posedge clock) begin
      req_stall_s <= req_stall;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_rsps.insert(expected_rsps.size(), coalesce(req_word));
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_rsp++;
         if (expected_rsps.size() == 0) begin
            report("word with none expected", 64'(rsp_word.status), '0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_word.status == STS_FULL) n_full++;
            if (rsp_word.status == STS_DATA) n_drain++;
            if (rsp_word.status == STS_READY) n_ready++;
            if (rsp_word.status !== want.status) report("status", rsp_word.status, want.status);
            if (rsp_word.out_id !== want.out_id) report("out_id", rsp_word.out_id, want.out_id);
            if (rsp_word.out_elem_index !== want.out_elem_index)
               report("out_elem_index", rsp_word.out_elem_index, want.out_elem_index);
            if (rsp_word.out_sum !== want.out_sum)
               report("out_sum", rsp_word.out_sum, want.out_sum);
            if (rsp_word.out_last !== want.out_last)
               report("out_last", rsp_word.out_last, want.out_last);
            if (rsp_word.pending_calls !== want.pending_calls)
               report("pending_calls", rsp_word.pending_calls, want.pending_calls);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && idle_cycles >= IDLE_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic req_word_type mk(logic [1:0] t, logic [63:0] id, logic [3:0] ix,
                                       logic [31:0] g, logic l);
      req_word_type w;
      w.req_type = t; w.id = id; w.elem_index = ix; w.grad_value = g; w.last_of_call = l;
      return w;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic csr_write(logic [3:0] idx, logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_WINDOW_CALLS) win_calls = val;
      else if (idx == CSR_ROW_LEN) row_length = val[4:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      while ((pending_words.size() > 0 || expected_rsps.size() > 0 || req_valid)
             && !timed_out) begin
         @(posedge clock);
      end
      repeat (60) @(posedge clock);
   endtask

   // random batch: mixed requests, window-closing adds, then drains
   task automatic random_batch(int n_items, int pool);
      logic [63:0] ids [$];
      int rl, w;
      rl = (row_length < 1) ? 1 : (row_length > ROWMAX ? ROWMAX : row_length);
      w = (win_calls == 0) ? 1 : win_calls;
      for (int i = 0; i < pool; i++) ids.insert(ids.size(), rand64());
      for (int i = 0; i < n_items; i++) begin
         int r;
         r = $urandom_range(0, 99);
         if (r < 80)
            enqueue(mk(REQ_ADD, ids[$urandom_range(0, pool-1)],
               4'($urandom_range(0, rl-1)), $urandom, ($urandom_range(0, 5) == 0)));
         else if (r < 88)
            enqueue(mk(REQ_ADD, rand64(), 4'($urandom), $urandom, 1'($urandom)));
         else if (r < 94)
            enqueue(mk(REQ_DRAIN, rand64(), 4'($urandom), $urandom, 1'($urandom)));
         else if (r < 96)
            enqueue(mk(REQ_FLUSH, rand64(), 4'($urandom), $urandom, 1'($urandom)));
         else
            enqueue(mk(REQ_NOP, rand64(), 4'($urandom), $urandom, 1'($urandom)));
      end
      for (int i = 0; i < w; i++)
         enqueue(mk(REQ_ADD, ids[0], 0, $urandom, 1'b1));
      for (int i = 0; i < pool * rl + 2; i++)
         enqueue(mk(REQ_DRAIN, '0, '0, '0, 1'b0));
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) keys[i] = '0;
      for (int i = 0; i < DEPTH*ROWMAX; i++) sums[i] = '0;
      clear_batch();
      win_calls = 1;
      row_length = 1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_write(CSR_WINDOW_CALLS, 8'd2);
      csr_write(CSR_ROW_LEN, 8'd16);
      enqueue(mk(REQ_DRAIN, '0, 0, 0, 0));
      enqueue(mk(REQ_ADD, 64'h8000_0000_0000_0000, 0, 32'h7fff_ffff, 0));
      enqueue(mk(REQ_ADD, 64'h8000_0000_0000_0000, 0, 32'h0000_0001, 0));
      enqueue(mk(REQ_ADD, 64'h7fff_ffff_ffff_ffff, 15, 32'h8000_0000, 0));
      enqueue(mk(REQ_ADD, 64'hffff_ffff_ffff_ffff, 15, 32'hffff_ffff, 1));
      enqueue(mk(REQ_NOP, '1, '1, '1, 1));
      enqueue(mk(REQ_ADD, 64'h0, 7, 32'h1234_5678, 1));
      enqueue(mk(REQ_ADD, 64'h5, 1, 32'h1, 1));
      enqueue(mk(REQ_DRAIN, '0, 0, 0, 0));
      enqueue(mk(REQ_DRAIN, '0, 0, 0, 0));
      settle();
      csr_write(CSR_ROW_LEN, 8'd2);
      for (int i = 0; i < 6; i++) enqueue(mk(REQ_DRAIN, '0, 0, 0, 0));
      enqueue(mk(REQ_FLUSH, '0, 0, 0, 0));
      enqueue(mk(REQ_ADD, 64'h9, 3, 32'h5, 1));
      enqueue(mk(REQ_ADD, 64'h9, 3, 32'h5, 1));
      enqueue(mk(REQ_DRAIN, '0, 0, 0, 0));
      settle();
      // full table with row_len 1
      csr_write(CSR_ROW_LEN, 8'd0);
      csr_write(CSR_WINDOW_CALLS, 8'd0);
      for (int i = 0; i < DEPTH + 3; i++)
         enqueue(mk(REQ_ADD, 64'(i), 0, 32'(i), 0));
      enqueue(mk(REQ_ADD, 64'd1000, 0, 1, 1));
      enqueue(mk(REQ_ADD, 64'd1, 0, 1, 1));
      for (int i = 0; i < DEPTH + 1; i++) enqueue(mk(REQ_DRAIN, '0, 0, 0, 0));
      settle();
      csr_write(CSR_WINDOW_CALLS, 8'd255);
      csr_write(CSR_ROW_LEN, 8'd31);
      for (int i = 0; i < 300; i++)
         enqueue(mk(REQ_ADD, 64'd3, 0, 1, 1));
      enqueue(mk(REQ_FLUSH, '0, 0, 0, 0));
      settle();

      for (int b = 0; b < 13 && !timed_out; b++) begin
         csr_write(CSR_WINDOW_CALLS, 8'($urandom_range(1, 8)));
         csr_write(CSR_ROW_LEN, (b % 5 == 4) ? 8'd16 : 8'($urandom_range(1, 4)));
         random_batch($urandom_range(20, 45), (b % 6 == 0) ? 70 : $urandom_range(1, 8));
         settle();
      end

      $display("run covered %0d responses: %0d drained, %0d table-full drops, %0d batch-ready",
               n_rsp, n_drain, n_full, n_ready);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ugc_pkg.sv
rtl/ugc_key_mem.sv
rtl/ugc_sum_mem.sv
rtl/unique_id_gradient_coalescer.sv
tb/tb.sv
